// ===== rtl/gmab_pkg.sv =====
package gmab_pkg;

   localparam int MAX_NODES  = 64;
   localparam int COUNT_W    = 7;
   localparam int ROW_W      = 6;
   localparam int MASK_W     = 64;
   localparam int RATIO_W    = 12;
   localparam int CAND_W     = 4;
   localparam int CAND_SQ_W  = 2 * CAND_W;
   localparam int SCALE_W    = 8;
   localparam int TARGET_W   = RATIO_W + COUNT_W;
   localparam int DIST_W     = TARGET_W + 1;
   localparam int CAND_SLOTS = 1 << CAND_W;

   // reciprocal divide of small exact multiples
   localparam int RECIP_SHIFT = 12;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam int QUOT_W      = COUNT_W + RECIP_W;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USED_W = ROW_W + MASK_W + 2 * COUNT_W;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ASPECT_RATIO_ADDR = 2'd0;
   localparam logic [RATIO_W-1:0]    ASPECT_RATIO_RESET    = 12'd256;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] height;
      logic [COUNT_W-1:0] width;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_PRODUCT,
      FRONT_SEARCH,
      FRONT_PICK,
      FRONT_WIDTH,
      FRONT_PUSH
   } front_state_type;

   typedef logic [CAND_SLOTS-1:0][MAX_NODES:0] div_table_type;

   // bit [f][n] set when f divides a nonzero n
   function automatic div_table_type build_div_table();
      div_table_type t;
      t = '0;
      for (int f = 1; f < CAND_SLOTS; f++) begin
         for (int k = 1; k * f <= MAX_NODES; k++) begin
            t[f][k * f] = 1'b1;
         end
      end
      return t;
   endfunction

   localparam div_table_type DIV_TABLE = build_div_table();

   localparam logic [RECIP_W-1:0] RECIP_TABLE [CAND_SLOTS] = '{
      RECIP_W'(0),
      RECIP_W'(RECIP_ONE),
      RECIP_W'((RECIP_ONE + 1) / 2),
      RECIP_W'((RECIP_ONE + 2) / 3),
      RECIP_W'((RECIP_ONE + 3) / 4),
      RECIP_W'((RECIP_ONE + 4) / 5),
      RECIP_W'((RECIP_ONE + 5) / 6),
      RECIP_W'((RECIP_ONE + 6) / 7),
      RECIP_W'((RECIP_ONE + 7) / 8),
      RECIP_W'(0), RECIP_W'(0), RECIP_W'(0), RECIP_W'(0),
      RECIP_W'(0), RECIP_W'(0), RECIP_W'(0)
   };

endpackage

// ===== rtl/gmab_front.sv =====
module gmab_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gmab_pkg::COUNT_W-1:0]   req_count,
   input  logic [gmab_pkg::RATIO_W-1:0]   cfg_ratio,
   input  gmab_pkg::queue_status_type     queue_status,
   output logic                           push_valid,
   output gmab_pkg::job_type              push_job
);
   import gmab_pkg::*;

   front_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [TARGET_W-1:0]   target_ff;
   logic [CAND_W-1:0]     cand_ff, cur_ff, prev_ff;
   logic [COUNT_W-1:0]    height_ff, width_ff;

   logic [COUNT_W-1:0]    count_sat;
   logic [CAND_SQ_W-1:0]  cand_sq, cur_sq, prev_sq;
   logic                  stop_hit, past_root, divisible;
   logic signed [DIST_W-1:0] d_prev, d_cur;
   logic [QUOT_W-1:0]     quot;

   assign count_sat = (req_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : req_count;
   assign cand_sq   = CAND_SQ_W'(cand_ff * cand_ff);
   assign cur_sq    = CAND_SQ_W'(cur_ff * cur_ff);
   assign prev_sq   = CAND_SQ_W'(prev_ff * prev_ff);
   assign stop_hit  = TARGET_W'({cur_sq, SCALE_W'(0)}) >= target_ff;
   assign past_root = COUNT_W'(cand_sq) > count_ff || cand_sq[CAND_SQ_W-1];
   assign divisible = DIV_TABLE[cand_ff][count_ff];

   // true distance of f*f*256 from ratio*n
   always_comb begin
      d_prev = DIST_W'($signed({1'b0, TARGET_W'({prev_sq, SCALE_W'(0)})}))
             - DIST_W'($signed({1'b0, target_ff}));
      d_cur  = DIST_W'($signed({1'b0, TARGET_W'({cur_sq, SCALE_W'(0)})}))
             - DIST_W'($signed({1'b0, target_ff}));
      if (d_prev < 0) d_prev = -d_prev;
      if (d_cur < 0) d_cur = -d_cur;
   end

   assign quot = QUOT_W'(count_ff) * QUOT_W'(RECIP_TABLE[height_ff[CAND_W-1:0]]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE:    if (req_valid && req_count != '0) state_in = FRONT_PRODUCT;
         FRONT_PRODUCT: state_in = FRONT_SEARCH;
         FRONT_SEARCH:  if (stop_hit || past_root) state_in = FRONT_PICK;
         FRONT_PICK:    state_in = FRONT_WIDTH;
         FRONT_WIDTH:   state_in = FRONT_PUSH;
         FRONT_PUSH:    if (!queue_status.full) state_in = FRONT_IDLE;
         default:       state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         FRONT_IDLE: req_ready  = 1'b1;
         FRONT_PUSH: push_valid = !queue_status.full;
         default: begin
            req_ready  = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   assign push_job = '{count: count_ff, height: height_ff, width: width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         FRONT_IDLE: begin
            count_ff <= count_sat;
            cand_ff  <= CAND_W'(2);
            cur_ff   <= CAND_W'(1);
            prev_ff  <= CAND_W'(1);
         end
         FRONT_PRODUCT: target_ff <= TARGET_W'(cfg_ratio) * TARGET_W'(count_ff);
         FRONT_SEARCH: begin
            if (!stop_hit && !past_root && divisible) begin
               prev_ff <= cur_ff;
               cur_ff  <= cand_ff;
            end
            cand_ff <= cand_ff + CAND_W'(1);
         end
         FRONT_PICK:  height_ff <= COUNT_W'((d_prev <= d_cur) ? prev_ff : cur_ff);
         FRONT_WIDTH: width_ff  <= quot[RECIP_SHIFT +: COUNT_W];
         default: ;
      endcase
   end

endmodule

// ===== rtl/gmab_queue.sv =====
module gmab_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  gmab_pkg::job_type           push_job,
   input  logic                        pop,
   output gmab_pkg::job_type           pop_job,
   output gmab_pkg::queue_status_type  status
);
   import gmab_pkg::*;

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  fill_ff;
   logic               do_push, do_pop;

   assign status.full  = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = fill_ff == '0;
   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         fill_ff <= fill_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
   end

endmodule

// ===== rtl/gmab_back.sv =====
module gmab_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gmab_pkg::queue_status_type    queue_status,
   input  gmab_pkg::job_type             job,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [gmab_pkg::ROW_W-1:0]    out_index,
   output logic [gmab_pkg::MASK_W-1:0]   out_bits,
   output logic [gmab_pkg::COUNT_W-1:0]  out_height,
   output logic [gmab_pkg::COUNT_W-1:0]  out_width,
   output logic                          out_last
);
   import gmab_pkg::*;

   logic                busy_ff;
   job_type             job_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COUNT_W-1:0]  col_ff;
   logic                out_valid_ff;
   logic [ROW_W-1:0]    out_index_ff;
   logic [MASK_W-1:0]   out_bits_ff;
   logic [COUNT_W-1:0]  out_height_ff, out_width_ff;
   logic                out_last_ff;

   logic                load, last;
   logic [COUNT_W:0]    r_ext, n_ext, w_ext, r_next, r_down;
   logic                right_ok, left_ok, down_ok, up_ok;
   logic [MASK_W-1:0]   mask;

   assign pop  = !busy_ff && !queue_status.empty;
   assign load = busy_ff && (!out_valid_ff || out_ready);

   assign r_ext  = (COUNT_W + 1)'(row_ff);
   assign n_ext  = (COUNT_W + 1)'(job_ff.count);
   assign w_ext  = (COUNT_W + 1)'(job_ff.width);
   assign r_next = r_ext + (COUNT_W + 1)'(1);
   assign r_down = r_ext + w_ext;

   // horizontal moves stay inside one grid row
   assign right_ok = (r_next < n_ext) && (col_ff != job_ff.width - COUNT_W'(1));
   assign left_ok  = (row_ff != '0) && (col_ff != '0);
   assign down_ok  = r_down < n_ext;
   assign up_ok    = r_ext >= w_ext;
   assign last     = r_next == n_ext;

   always_comb begin
      mask = '0;
      if (right_ok) mask[ROW_W'(r_next)] = 1'b1;
      if (left_ok)  mask[row_ff - ROW_W'(1)] = 1'b1;
      if (down_ok)  mask[ROW_W'(r_down)] = 1'b1;
      if (up_ok)    mask[ROW_W'(r_ext - w_ext)] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
         end else if (load && last) begin
            busy_ff <= 1'b0;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= job;
         row_ff <= '0;
         col_ff <= '0;
      end else if (load) begin
         row_ff <= row_ff + ROW_W'(1);
         col_ff <= (col_ff == job_ff.width - COUNT_W'(1)) ? '0 : col_ff + COUNT_W'(1);
      end
      if (load) begin
         out_index_ff  <= row_ff;
         out_bits_ff   <= mask;
         out_height_ff <= job_ff.height;
         out_width_ff  <= job_ff.width;
         out_last_ff   <= last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_index  = out_index_ff;
   assign out_bits   = out_bits_ff;
   assign out_height = out_height_ff;
   assign out_width  = out_width_ff;
   assign out_last   = out_last_ff;

   // a node never neighbours itself
   a_no_self_loop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !out_bits_ff[out_index_ff])
      else $error("row marks its own node");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((2 * COUNT_W)'(out_index_ff)
         < (2 * COUNT_W)'(out_height_ff) * (2 * COUNT_W)'(out_width_ff)))
      else $error("row index outside the grid");

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> ((2 * COUNT_W)'(out_index_ff) + (2 * COUNT_W)'(1)
         == (2 * COUNT_W)'(out_height_ff) * (2 * COUNT_W)'(out_width_ff)))
      else $error("last row flag on a row that is not final");

endmodule

// ===== rtl/grid_mesh_adjacency_builder.sv =====
// channel   dir  handshake                       payload
// req       in   req_tvalid / req_tready         node_count
// rsp       out  rsp_tvalid / rsp_tready         row_index, row_bits, grid_height,
//                                                grid_width, last_row on rsp_tlast
// csr       in   csr_psel / csr_penable, pready  aspect_ratio at byte address 0
//
// the front searches divisors, one candidate per cycle
// the back emits one adjacency row per cycle while rsp_tready allows, and pops the next job after a last row
// with the queue between them the slower half sets the sustained rate
// synchronous active-high reset empties the queue and idles both halves, ratio returns to 1.0
// a stalled rsp side holds the output register; the front keeps working until the queue fills
module grid_mesh_adjacency_builder (
   input  logic                              clock,
   input  logic                              reset,
   // node_count [6:0], zero [7]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gmab_pkg::REQ_DATA_W-1:0]   req_tdata,
   // row_index [5:0], row_bits [69:6], grid_height [76:70], grid_width [83:77], zero [87:84]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gmab_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gmab_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gmab_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gmab_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import gmab_pkg::*;

   logic [RATIO_W-1:0]  ratio_ff;
   logic                push_valid, pop;
   job_type             push_job, pop_job;
   queue_status_type    queue_status;
   logic [ROW_W-1:0]    row_index;
   logic [MASK_W-1:0]   row_bits;
   logic [COUNT_W-1:0]  grid_height, grid_width;

   // register file: only the aspect ratio, written on the access phase
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= ASPECT_RATIO_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == CSR_ASPECT_RATIO_ADDR) begin
         ratio_ff <= csr_pwdata[RATIO_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_ASPECT_RATIO_ADDR) ? CSR_DATA_W'(ratio_ff) : '0;

   // front: saturate the count, walk divisors, pick height and width
   gmab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_count    (req_tdata[COUNT_W-1:0]),
      .cfg_ratio    (ratio_ff),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_job     (push_job)
   );

   // short job queue decouples the search from row emission
   gmab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .pop_job    (pop_job),
      .status     (queue_status)
   );

   // back: one row mask per node into the output register
   gmab_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .job          (pop_job),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_index    (row_index),
      .out_bits     (row_bits),
      .out_height   (grid_height),
      .out_width    (grid_width),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_USED_W)'(0), grid_width, grid_height, row_bits, row_index};

endmodule

// ===== tb/sv/grid_mesh_adjacency_builder_test.sv =====
`timescale 1ns / 1ps

module grid_mesh_adjacency_builder_test;
   import gmab_pkg::*;

   // one adjacency row as it leaves the block
   typedef struct packed {
      logic [ROW_W-1:0]   row_index;
      logic [MASK_W-1:0]  row_bits;
      logic [COUNT_W-1:0] grid_height;
      logic [COUNT_W-1:0] grid_width;
      logic               last_row;
   } mesh_row_type;

   // keeps its own copy of the ratio register and the rows still owed by the block
   class mesh_scoreboard;
      logic [RATIO_W-1:0] aspect_ratio;
      mesh_row_type       owed_rows[$];
      int                 mismatch_count;

      function new();
         aspect_ratio   = ASPECT_RATIO_RESET;
         mismatch_count = 0;
      endfunction

      // divisor walk, nearest pick, then one neighbour mask per node
      function void predict_mesh_rows(logic [COUNT_W-1:0] count);
         int unsigned  n, cur, prev, nxt, h, w, target;
         longint       dist_prev, dist_cur;
         mesh_row_type row;
         n = count;
         if (n == 0) return;
         if (n > MAX_NODES) n = MAX_NODES;
         target = aspect_ratio * n;
         cur    = 1;
         prev   = 1;
         forever begin
            if (256 * cur * cur >= target) break;
            nxt = 0;
            for (int unsigned f = cur + 1; f * f <= n; f++) begin
               if (n % f == 0) begin
                  nxt = f;
                  break;
               end
            end
            if (nxt == 0) break;
            prev = cur;
            cur  = nxt;
         end
         // true distance, a tie goes to the earlier divisor
         dist_prev = longint'(256 * prev * prev) - longint'(target);
         dist_cur  = longint'(256 * cur * cur) - longint'(target);
         if (dist_prev < 0) dist_prev = -dist_prev;
         if (dist_cur < 0) dist_cur = -dist_cur;
         h = (dist_prev <= dist_cur) ? prev : cur;
         w = n / h;
         for (int unsigned r = 0; r < n; r++) begin
            row             = '0;
            row.row_index   = r[ROW_W-1:0];
            row.grid_height = h[COUNT_W-1:0];
            row.grid_width  = w[COUNT_W-1:0];
            row.last_row    = (r + 1 == n);
            if (r + 1 < n && (r + 1) % w != 0) row.row_bits[r + 1] = 1'b1;
            if (r >= 1 && r % w != 0) row.row_bits[r - 1] = 1'b1;
            if (r + w < n) row.row_bits[r + w] = 1'b1;
            if (r >= w) row.row_bits[r - w] = 1'b1;
            owed_rows = {owed_rows, row};
         end
      endfunction

      task flag_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task check_row(logic [RSP_DATA_W-1:0] data, logic last);
         mesh_row_type want;
         mesh_row_type got;
         if (owed_rows.size() == 0) begin
            flag_mismatch("row arrived with nothing owed");
            return;
         end
         want            = owed_rows.pop_front();
         got.row_index   = data[ROW_W-1:0];
         got.row_bits    = data[ROW_W +: MASK_W];
         got.grid_height = data[ROW_W + MASK_W +: COUNT_W];
         got.grid_width  = data[ROW_W + MASK_W + COUNT_W +: COUNT_W];
         got.last_row    = last;
         if (got.row_index !== want.row_index)
            flag_mismatch($sformatf("row_index %0d, want %0d", got.row_index, want.row_index));
         if (got.row_bits !== want.row_bits)
            flag_mismatch($sformatf("row %0d row_bits %h, want %h",
                                    want.row_index, got.row_bits, want.row_bits));
         if (got.grid_height !== want.grid_height)
            flag_mismatch($sformatf("row %0d grid_height %0d, want %0d",
                                    want.row_index, got.grid_height, want.grid_height));
         if (got.grid_width !== want.grid_width)
            flag_mismatch($sformatf("row %0d grid_width %0d, want %0d",
                                    want.row_index, got.grid_width, want.grid_width));
         if (got.last_row !== want.last_row)
            flag_mismatch($sformatf("row %0d last_row %b, want %b",
                                    want.row_index, got.last_row, want.last_row));
      endtask

      function int owed();
         return owed_rows.size();
      endfunction
   endclass

   // settling cycles allowed after the last owed row; the front drops a zero-count request at once
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 56;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // idling knobs, percent per cycle, changed only while the block is idle
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   // long receiver hold-off, counted down by the receiver process
   int hold_off_cycles    = 0;

   mesh_scoreboard sb;

   grid_mesh_adjacency_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // every row transfer is checked against the oldest owed row
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_row(rsp_tdata, rsp_tlast);
   end

   // apb write: setup cycle, then access cycle until pready
   task write_ratio(input logic [RATIO_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[RATIO_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ASPECT_RATIO_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.aspect_ratio = value;
   endtask

   // one request transfer; valid stays up if the next request follows at once
   task send_request(input logic [COUNT_W-1:0] count);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(count);
      do @(posedge clock); while (!req_tready);
      sb.predict_mesh_rows(count);
   endtask

   // wait for every owed row, then let the block settle
   task drain_block();
      req_tvalid <= 1'b0;
      while (sb.owed() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly real mesh sizes with random content, some zero and oversized counts
   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned composites[13] = '{4, 6, 8, 9, 12, 16, 18, 24, 30, 36, 48, 60, 64};
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 4) return '0;
      if (roll < 12) return COUNT_W'($urandom_range(127, MAX_NODES + 1));
      if (roll < 32) return COUNT_W'(composites[$urandom_range(12)]);
      return COUNT_W'($urandom_range(MAX_NODES, 1));
   endfunction

   // ratios mostly in the useful range up to about 6.0, sometimes anywhere
   function automatic logic [RATIO_W-1:0] pick_ratio();
      if ($urandom_range(3) == 0) return RATIO_W'($urandom_range(4095));
      return RATIO_W'($urandom_range(1536));
   endfunction

   initial begin
      // unit ratio: primes, squares, composites, zero, saturation, top bit of the count
      int unsigned unit_counts[] = '{1, 2, 3, 4, 6, 7, 12, 16, 36, 60, 64, 65, 127, 0, 48};
      // ratio zero stops the walk at the first divisor
      int unsigned zero_counts[] = '{12, 64, 1, 9};
      // full-scale ratio walks to the last divisor
      int unsigned full_counts[] = '{64, 36, 2, 63, 100, 24};
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      write_ratio(12'd256);
      foreach (unit_counts[i]) send_request(COUNT_W'(unit_counts[i]));
      drain_block();
      write_ratio(12'd0);
      foreach (zero_counts[i]) send_request(COUNT_W'(zero_counts[i]));
      drain_block();
      write_ratio(12'd4095);
      foreach (full_counts[i]) send_request(COUNT_W'(full_counts[i]));
      drain_block();

      // random phases, each with its own idling pattern and ratio
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: begin
               sender_idle_pct    = 61;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 61;
            end
            3, 5: begin
               sender_idle_pct    = 32;
               receiver_stall_pct = 32;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         write_ratio(pick_ratio());
         // receiver holds off while requests keep coming, so the queue fills
         if (p == 4) hold_off_cycles = 400;
         for (int k = 0; k < PHASE_ITEMS; k++) send_request(pick_count());
         drain_block();
      end

      if (sb.mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog well beyond the slowest correct run
   initial begin
      #800000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gmab_pkg.sv
rtl/gmab_front.sv
rtl/gmab_queue.sv
rtl/gmab_back.sv
rtl/grid_mesh_adjacency_builder.sv
tb/sv/grid_mesh_adjacency_builder_test.sv
